### src/rmst_pkg.sv
package rmst_pkg;

  // fixed field widths
  localparam int POS_W = 13;

  // defaults for the top level parameters
  localparam int DEF_LEAVES      = 4096;
  localparam int DEF_VALUE_WIDTH = 31;

  // leaf count after reset is capped at this
  localparam int LEAF_COUNT_CAP = 4096;

  // item kinds
  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic clr_step;
    logic upd_start;
    logic upd_step;
    logic qry_start;
    logic qry_step;
    logic load_result;
  } rmst_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic pos_ok;
    logic clr_last;
    logic up_last;
    logic q_more;
  } rmst_stat_t;

endpackage

### src/rmst_ctrl.sv
module rmst_ctrl import rmst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       mode,
  input  logic       cfg_we,
  input  rmst_stat_t stat,
  output rmst_cmd_t  cmd,
  output logic       busy,
  output logic       done
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_QRY
  } state_t;

  state_t state;
  state_t state_next;

  // command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (mode == MODE_QUERY) begin
            cmd.qry_start = 1'b1;
            state_next    = ST_QRY;
          end else if (stat.pos_ok) begin
            cmd.upd_start = 1'b1;
            state_next    = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        cmd.upd_step = 1'b1;
        if (stat.up_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_QRY: begin
        cmd.qry_step = 1'b1;
        if (!stat.q_more) begin
          cmd.load_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
    // a new leaf count wipes the tree
    if (cfg_we) begin
      state_next = ST_CLEAR;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != ST_IDLE);
      done  <= cmd.load_result & ~cfg_we;
    end
  end

  // a result beat only closes a query walk and leaves the block free
  assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state == ST_QRY) && !busy))
    else $error("result beat without a finished query");

  // a leaf count write always starts the clearing sweep
  assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (state == ST_CLEAR))
    else $error("config write did not start clearing");

  // at most one datapath operation per cycle
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr_step, cmd.upd_start, cmd.upd_step, cmd.qry_start, cmd.qry_step}))
    else $error("conflicting datapath commands");

endmodule

### src/rmst_datapath.sv
module rmst_datapath import rmst_pkg::*; #(
  parameter int LEAVES      = DEF_LEAVES,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  rmst_cmd_t              cmd,
  output rmst_stat_t             stat,
  input  logic                   cfg_we,
  input  logic [POS_W-1:0]       cfg_data,
  input  logic [POS_W-1:0]       position,
  input  logic [VALUE_WIDTH-1:0] new_value,
  input  logic [POS_W-1:0]       range_low,
  input  logic [POS_W-1:0]       range_high,
  output logic [VALUE_WIDTH-1:0] max_value
);

  localparam int NODES = 2 * LEAVES;
  localparam int AW    = $clog2(NODES);
  localparam int IW    = AW + 1;
  localparam int LW    = $clog2(LEAVES + 1);
  localparam int CW    = (POS_W > LW) ? POS_W : LW;
  localparam int LEAF_RESET = (LEAVES < LEAF_COUNT_CAP) ? LEAVES : LEAF_COUNT_CAP;

  // tree storage, node 1 is the root, leaves from LEAVES upward
  logic [VALUE_WIDTH-1:0] node_max [NODES];
  logic [VALUE_WIDTH-1:0] rd0;
  logic [VALUE_WIDTH-1:0] rd1;

  logic [LW-1:0]          leaf_count;
  logic [AW-1:0]          clr_cnt;
  logic [AW-1:0]          up_idx;
  logic [VALUE_WIDTH-1:0] cur;
  logic [IW-1:0]          qa;
  logic [IW-1:0]          qb;
  logic                   rv0;
  logic                   rv1;
  logic [VALUE_WIDTH-1:0] best;

  logic [POS_W-1:0]       cfg_v;
  logic [LW-1:0]          leaf_count_next;
  logic [AW-1:0]          leaf_idx;
  logic [POS_W-1:0]       lo_c;
  logic [CW-1:0]          hi_c;
  logic                   q_empty;
  logic [IW-1:0]          qa_init;
  logic [IW-1:0]          qb_init;
  logic [IW-1:0]          qb_dec;
  logic [AW-1:0]          up_parent;
  logic [VALUE_WIDTH-1:0] pmax;
  logic [VALUE_WIDTH-1:0] sel0;
  logic [VALUE_WIDTH-1:0] sel1;
  logic [VALUE_WIDTH-1:0] m01;
  logic [VALUE_WIDTH-1:0] best_next;
  logic                   wen;
  logic [AW-1:0]          waddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [AW-1:0]          raddr0;
  logic [AW-1:0]          raddr1;

  // leaf count saturates into 1..LEAVES
  always_comb begin
    cfg_v = (cfg_data == '0) ? POS_W'(1) : cfg_data;
    if (CW'(cfg_v) > CW'(LEAVES)) begin
      leaf_count_next = LW'(LEAVES);
    end else begin
      leaf_count_next = LW'(cfg_v);
    end
  end

  // update position check and leaf address
  assign stat.pos_ok = (position != '0) && (CW'(position) <= CW'(leaf_count));
  assign leaf_idx    = AW'(LEAVES) + AW'(position) - AW'(1);

  // query range clipping and walk bounds
  always_comb begin
    lo_c    = (range_low == '0) ? POS_W'(1) : range_low;
    hi_c    = (CW'(range_high) > CW'(leaf_count)) ? CW'(leaf_count) : CW'(range_high);
    q_empty = CW'(lo_c) > hi_c;
    if (q_empty) begin
      qa_init = '0;
      qb_init = '0;
    end else begin
      qa_init = IW'(LEAVES) + IW'(lo_c) - IW'(1);
      qb_init = IW'(LEAVES) + IW'(hi_c);
    end
  end

  // walk status
  assign up_parent     = {1'b0, up_idx[AW-1:1]};
  assign stat.up_last  = (up_parent == AW'(1));
  assign stat.q_more   = (qa < qb);
  assign stat.clr_last = (clr_cnt == AW'(NODES - 1));
  assign qb_dec        = qb - IW'(1);

  // max of current node and its sibling
  assign pmax = (cur > rd0) ? cur : rd0;

  // fold the two returned nodes into the running max
  always_comb begin
    sel0      = rv0 ? rd0 : '0;
    sel1      = rv1 ? rd1 : '0;
    m01       = (sel0 > sel1) ? sel0 : sel1;
    best_next = (best > m01) ? best : m01;
  end

  // write port select
  always_comb begin
    wen   = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd.clr_step) begin
      wen   = 1'b1;
      waddr = clr_cnt;
    end else if (cmd.upd_start) begin
      wen   = 1'b1;
      waddr = leaf_idx;
      wdata = new_value;
    end else if (cmd.upd_step) begin
      wen   = 1'b1;
      waddr = up_parent;
      wdata = pmax;
    end
  end

  // read port addresses: sibling or left edge on port 0, right edge on port 1
  always_comb begin
    if (cmd.qry_step) begin
      raddr0 = qa[AW-1:0];
    end else if (cmd.upd_start) begin
      raddr0 = leaf_idx ^ AW'(1);
    end else begin
      raddr0 = up_parent ^ AW'(1);
    end
    raddr1 = qb_dec[AW-1:0];
  end

  // tree memory, one write and two registered reads
  always_ff @(posedge clk) begin
    if (wen) begin
      node_max[waddr] <= wdata;
    end
    rd0 <= node_max[raddr0];
    rd1 <= node_max[raddr1];
  end

  // leaf count register and clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_count <= LW'(LEAF_RESET);
      clr_cnt    <= '0;
    end else if (cfg_we) begin
      leaf_count <= leaf_count_next;
      clr_cnt    <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // upward walk of an update
  always_ff @(posedge clk) begin
    if (cmd.upd_start) begin
      up_idx <= leaf_idx;
      cur    <= new_value;
    end else if (cmd.upd_step) begin
      up_idx <= up_parent;
      cur    <= pmax;
    end
  end

  // bottom-up walk of a query, one level per cycle
  always_ff @(posedge clk) begin
    if (cmd.qry_start) begin
      qa   <= qa_init;
      qb   <= qb_init;
      rv0  <= 1'b0;
      rv1  <= 1'b0;
      best <= '0;
    end else if (cmd.qry_step) begin
      best <= best_next;
      if (stat.q_more) begin
        qa  <= (qa + IW'(qa[0])) >> 1;
        qb  <= (qb - IW'(qb[0])) >> 1;
        rv0 <= qa[0];
        rv1 <= qb[0];
      end else begin
        rv0 <= 1'b0;
        rv1 <= 1'b0;
      end
    end
    if (cmd.load_result) begin
      max_value <= best_next;
    end
  end

  // the update walk never writes above the root
  assert property (@(posedge clk) disable iff (rst)
    cmd.upd_step |-> (up_idx[AW-1:1] != '0))
    else $error("update walk passed the root");

endmodule

### src/range_max_segment_tree_core.sv
// range maximum segment tree with point update
// update: busy while the walk runs up to the root, one tree level per cycle
// query: a bottom-up walk ending in a result strobe, one level per cycle
//   using both read ports of the node memory; no result beat for updates
// reset and every leaf_count write clear all 2*LEAVES nodes, one per cycle, busy meanwhile
// the receiver cannot stall: done is high for exactly one cycle per query, none if a leaf_count write cuts it off
module range_max_segment_tree_core import rmst_pkg::*; #(
  parameter int LEAVES      = DEF_LEAVES,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   mode,
  input  logic [POS_W-1:0]       position,
  input  logic [VALUE_WIDTH-1:0] new_value,
  input  logic [POS_W-1:0]       range_low,
  input  logic [POS_W-1:0]       range_high,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] max_value,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [POS_W-1:0]       cfg_data
);

  rmst_cmd_t  cmd;
  rmst_stat_t stat;
  logic       cfg_we;

  // config beat is always taken
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  rmst_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode),
    .cfg_we (cfg_we),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  rmst_datapath #(
    .LEAVES      (LEAVES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .position   (position),
    .new_value  (new_value),
    .range_low  (range_low),
    .range_high (range_high),
    .max_value  (max_value)
  );

endmodule
